// File: rtl/dda_grid_raycast_column_top_assert.svh
// assertion macros for the raycaster
`ifndef DDA_GRID_RAYCAST_COLUMN_TOP_ASSERT_SVH
`define DDA_GRID_RAYCAST_COLUMN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DGR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("raycaster assertion failed");
`define DGR_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("raycaster reset assertion failed");
`else
`define DGR_ASSERT(lbl, clk, rstn, prop)
`define DGR_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// File: rtl/dgr_pkg.sv
package dgr_pkg;

    localparam int MAP_SIZE   = 32;
    localparam int MAP_BITS   = 5;
    localparam int ADDR_W     = 2 * MAP_BITS;
    localparam int SCREEN_W   = 1920;
    localparam int SCREEN_H   = 1080;
    localparam int FRAC_BITS  = 16;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int WALK_STEPS = 2 * MAP_SIZE + 4;
    localparam int DIV_NW     = 40;
    localparam int DIV_DW     = 22;
    localparam int DIV_CW     = 6;

    // (2 * column << 16) / 1920 equals (column << 10) / 15, done as a
    // reciprocal multiply, exact for dividends below 2^22
    localparam logic [22:0] CAM_RECIP = 23'd4473925;
    localparam int          CAM_SHIFT = 26;

    localparam logic [21:0] DIST_MAX    = 22'h3FFFFF;
    localparam logic [2:0]  COLOR_BLACK = 3'd4;

    localparam logic [2:0] CFG_POS_X   = 3'd0;
    localparam logic [2:0] CFG_POS_Y   = 3'd1;
    localparam logic [2:0] CFG_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_MUL, S_RAYX, S_RAYY,
        S_STEP, S_CHECK, S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        OP_DX, OP_SDX, OP_DY, OP_SDY, OP_DIST, OP_LH
    } t_div_op;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_map_req;

endpackage

// File: rtl/dgr_div.sv
module dgr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dgr_pkg::DIV_NW-1:0]    i_dividend,
    input  logic [dgr_pkg::DIV_DW-1:0]    i_divisor,
    output logic                          o_done,
    output logic [dgr_pkg::DIV_NW-1:0]    o_quotient
);

    logic                       r_busy;
    logic                       r_done;
    logic [dgr_pkg::DIV_CW-1:0] r_cnt;
    logic [dgr_pkg::DIV_NW-1:0] r_q;
    logic [dgr_pkg::DIV_DW-1:0] r_rem;
    logic [dgr_pkg::DIV_DW-1:0] r_den;

    logic [dgr_pkg::DIV_DW:0]   sh;
    logic [dgr_pkg::DIV_DW+1:0] trial;
    logic                       ge;

    // one quotient bit per cycle, restoring
    assign sh    = {r_rem, r_q[dgr_pkg::DIV_NW-1]};
    assign trial = {1'b0, sh} - {2'b0, r_den};
    assign ge    = !trial[dgr_pkg::DIV_DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= dgr_pkg::DIV_CW'(dgr_pkg::DIV_NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[dgr_pkg::DIV_NW-2:0], ge};
            r_rem <= ge ? trial[dgr_pkg::DIV_DW-1:0] : sh[dgr_pkg::DIV_DW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// File: rtl/dgr_map.sv
module dgr_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dgr_pkg::t_map_req i_req,
    output logic [7:0]        o_rdata,
    output logic              o_clearing
);

    logic [7:0]                 r_mem [0:(1 << dgr_pkg::ADDR_W)-1];
    logic [7:0]                 r_rdata;
    logic                       r_clearing;
    logic [dgr_pkg::ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {dgr_pkg::ADDR_W{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // requested writes only come while the top is idle and read data is only used during a walk, so no overlap
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

// File: rtl/dda_grid_raycast_column_top.sv
// channel   direction  handshake                  fields
// request   in         start high, busy low       i_command i_cell_row i_cell_col
//                                                 i_cell_value i_column
// result    out        o_valid, one cycle         o_out_column o_draw_start o_draw_end
//                                                 o_color_code o_hit_side o_wall_distance
//                                                 o_escaped
// config    in         i_cfg_we, no wait          i_cfg_idx i_cfg_data
//
// a cast runs up to six divisions on the shared bit-serial divider, plus a map
// memory read for each grid step, up to 68 steps.
// the camera offset comes from a reciprocal multiply in the accepting cycle.
// after reset the map memory is cleared, one cell per cycle over all 1024 cells,
// with busy high. the result is shown for one cycle; the receiver cannot stall.
`include "dda_grid_raycast_column_top_assert.svh"

module dda_grid_raycast_column_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [4:0]  i_cell_row,
    input  logic [4:0]  i_cell_col,
    input  logic [7:0]  i_cell_value,
    input  logic [10:0] i_column,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_data,
    output logic        o_valid,
    output logic [10:0] o_out_column,
    output logic [10:0] o_draw_start,
    output logic [10:0] o_draw_end,
    output logic [2:0]  o_color_code,
    output logic        o_hit_side,
    output logic [21:0] o_wall_distance,
    output logic        o_escaped
);

    localparam int NW = dgr_pkg::DIV_NW;
    localparam int DW = dgr_pkg::DIV_DW;
    localparam int F  = dgr_pkg::FRAC_BITS;

    dgr_pkg::t_state  r_state, n_state;
    dgr_pkg::t_div_op r_op, n_op;

    logic        [20:0] r_pos_x, r_pos_y;
    logic signed [17:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;

    logic        [10:0] r_col;
    logic signed [18:0] r_cam;
    logic signed [36:0] r_prod;
    logic signed [20:0] r_rx, r_ry;
    logic        [39:0] r_dx, r_dy, r_sdx, r_sdy;
    logic        [6:0]  r_mx, r_my;
    logic        [6:0]  r_n;
    logic               r_side;
    logic               r_hit;
    logic        [7:0]  r_cell;
    logic        [21:0] r_dist;
    logic        [39:0] r_lh;

    logic               r_valid;
    logic        [10:0] r_out_column, r_draw_start, r_draw_end;
    logic        [2:0]  r_color_code;
    logic               r_hit_side;
    logic        [21:0] r_wall_distance;
    logic               r_escaped;

    logic               div_start, div_done;
    logic [NW-1:0]      div_q, div_nd;
    logic [DW-1:0]      div_dv;
    logic [21:0]        q_sat;

    dgr_pkg::t_map_req  map_req;
    logic [7:0]         map_rdata;
    logic               map_clearing;

    logic [43:0]        cam_prod;
    logic signed [20:0] n_rx, n_ry;
    logic               xinf, yinf;
    logic [20:0]        mag_rx, mag_ry;
    logic [16:0]        frac_x, frac_y;

    logic               take_x;
    logic [6:0]         s_mx, s_my;
    logic [39:0]        s_sdx, s_sdy;
    logic               s_out;

    logic [5:0]         edge_cell;
    logic [20:0]        edge_pos;
    logic signed [22:0] edge_diff;
    logic [21:0]        num;
    logic [20:0]        den;

    logic [39:0]        lh, half;
    logic               big;
    logic [7:0]         cval;

    logic cast_req;

    assign cast_req = start && (r_state == dgr_pkg::S_IDLE) && (i_command == dgr_pkg::CMD_CAST);

    dgr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_nd),
        .i_divisor  (div_dv),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    dgr_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (map_req),
        .o_rdata    (map_rdata),
        .o_clearing (map_clearing)
    );

    // camera offset numerator over the screen width
    assign cam_prod = 44'({i_column, 10'b0}) * 44'(dgr_pkg::CAM_RECIP);

    // ray arithmetic
    assign n_rx   = 21'(r_dir_x) + 21'(r_prod >>> F);
    assign n_ry   = 21'(r_dir_y) + 21'(r_prod >>> F);
    assign xinf   = (r_rx == '0);
    assign yinf   = (r_ry == '0);
    assign mag_rx = r_rx[20] ? 21'(-r_rx) : 21'(r_rx);
    assign mag_ry = r_ry[20] ? 21'(-r_ry) : 21'(r_ry);
    assign frac_x = r_rx[20] ? {1'b0, r_pos_x[F-1:0]}
                             : 17'(dgr_pkg::ONE) - {1'b0, r_pos_x[F-1:0]};
    assign frac_y = r_ry[20] ? {1'b0, r_pos_y[F-1:0]}
                             : 17'(dgr_pkg::ONE) - {1'b0, r_pos_y[F-1:0]};

    // one dda step
    assign take_x = !xinf && (yinf || (r_sdx < r_sdy));
    assign s_mx   = take_x ? r_mx + (r_rx[20] ? 7'h7F : 7'h01) : r_mx;
    assign s_my   = take_x ? r_my : r_my + (r_ry[20] ? 7'h7F : 7'h01);
    assign s_sdx  = take_x ? r_sdx + r_dx : r_sdx;
    assign s_sdy  = (!take_x && !yinf) ? r_sdy + r_dy : r_sdy;
    assign s_out  = s_mx[6] || (s_mx[5:0] >= 6'(dgr_pkg::MAP_SIZE))
                 || s_my[6] || (s_my[5:0] >= 6'(dgr_pkg::MAP_SIZE));

    // distance from the viewer to the grid line that was crossed
    assign edge_cell = r_side ? 6'(r_my[5:0] + {5'b0, r_ry[20]})
                              : 6'(r_mx[5:0] + {5'b0, r_rx[20]});
    assign edge_pos  = r_side ? r_pos_y : r_pos_x;
    assign edge_diff = $signed({1'b0, edge_cell, {F{1'b0}}}) - $signed({2'b0, edge_pos});
    assign num       = edge_diff[22] ? 22'(-edge_diff) : edge_diff[21:0];
    assign den       = r_side ? mag_ry : mag_rx;

    assign q_sat = (div_q > NW'(dgr_pkg::DIST_MAX)) ? dgr_pkg::DIST_MAX : div_q[21:0];

    always_comb begin
        case (r_op)
            dgr_pkg::OP_DX: begin
                div_nd = NW'(1) << (2 * F);
                div_dv = {1'b0, mag_rx};
            end
            dgr_pkg::OP_SDX: begin
                div_nd = {7'b0, frac_x, {F{1'b0}}};
                div_dv = {1'b0, mag_rx};
            end
            dgr_pkg::OP_DY: begin
                div_nd = NW'(1) << (2 * F);
                div_dv = {1'b0, mag_ry};
            end
            dgr_pkg::OP_SDY: begin
                div_nd = {7'b0, frac_y, {F{1'b0}}};
                div_dv = {1'b0, mag_ry};
            end
            dgr_pkg::OP_DIST: begin
                div_nd = {2'b0, num, {F{1'b0}}};
                div_dv = {1'b0, den};
            end
            dgr_pkg::OP_LH: begin
                div_nd = NW'(dgr_pkg::SCREEN_H) << F;
                div_dv = r_dist;
            end
            default: begin
                div_nd = '0;
                div_dv = DW'(1);
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            dgr_pkg::S_CLEAR: begin
                if (!map_clearing) n_state = dgr_pkg::S_IDLE;
            end
            dgr_pkg::S_IDLE: begin
                if (cast_req) n_state = dgr_pkg::S_MUL;
            end
            dgr_pkg::S_DIV_GO: n_state = dgr_pkg::S_DIV_WAIT;
            dgr_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    unique case (r_op)
                        dgr_pkg::OP_DX: begin
                            n_state = dgr_pkg::S_DIV_GO;
                            n_op    = dgr_pkg::OP_SDX;
                        end
                        dgr_pkg::OP_SDX: begin
                            if (yinf) begin
                                n_state = dgr_pkg::S_STEP;
                            end else begin
                                n_state = dgr_pkg::S_DIV_GO;
                                n_op    = dgr_pkg::OP_DY;
                            end
                        end
                        dgr_pkg::OP_DY: begin
                            n_state = dgr_pkg::S_DIV_GO;
                            n_op    = dgr_pkg::OP_SDY;
                        end
                        dgr_pkg::OP_SDY: n_state = dgr_pkg::S_STEP;
                        dgr_pkg::OP_DIST: begin
                            if (q_sat == '0) begin
                                n_state = dgr_pkg::S_FINISH;
                            end else begin
                                n_state = dgr_pkg::S_DIV_GO;
                                n_op    = dgr_pkg::OP_LH;
                            end
                        end
                        dgr_pkg::OP_LH: n_state = dgr_pkg::S_FINISH;
                        default: n_state = dgr_pkg::S_FINISH;
                    endcase
                end
            end
            dgr_pkg::S_MUL:  n_state = dgr_pkg::S_RAYX;
            dgr_pkg::S_RAYX: n_state = dgr_pkg::S_RAYY;
            dgr_pkg::S_RAYY: begin
                if (!xinf) begin
                    n_state = dgr_pkg::S_DIV_GO;
                    n_op    = dgr_pkg::OP_DX;
                end else if (n_ry != '0) begin
                    n_state = dgr_pkg::S_DIV_GO;
                    n_op    = dgr_pkg::OP_DY;
                end else begin
                    n_state = dgr_pkg::S_STEP;
                end
            end
            dgr_pkg::S_STEP: n_state = s_out ? dgr_pkg::S_FINISH : dgr_pkg::S_CHECK;
            dgr_pkg::S_CHECK: begin
                if (map_rdata != 8'd0) begin
                    n_state = dgr_pkg::S_DIV_GO;
                    n_op    = (r_side && yinf) ? dgr_pkg::OP_LH : dgr_pkg::OP_DIST;
                end else if (r_n == 7'(dgr_pkg::WALK_STEPS - 1)) begin
                    n_state = dgr_pkg::S_FINISH;
                end else begin
                    n_state = dgr_pkg::S_STEP;
                end
            end
            dgr_pkg::S_FINISH: n_state = dgr_pkg::S_IDLE;
            default: n_state = dgr_pkg::S_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        busy          = (r_state != dgr_pkg::S_IDLE);
        div_start     = (r_state == dgr_pkg::S_DIV_GO);
        map_req.we    = start && (r_state == dgr_pkg::S_IDLE)
                     && (i_command == dgr_pkg::CMD_WRITE);
        map_req.waddr = {i_cell_row, i_cell_col};
        map_req.wdata = i_cell_value;
        map_req.raddr = {s_mx[dgr_pkg::MAP_BITS-1:0], s_my[dgr_pkg::MAP_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgr_pkg::S_CLEAR;
            r_op    <= dgr_pkg::OP_DX;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_valid <= (r_state == dgr_pkg::S_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 21'd1376256;
            r_pos_y   <= 21'd720896;
            r_dir_x   <= -18'sd65536;
            r_dir_y   <= 18'sd0;
            r_plane_x <= 18'sd0;
            r_plane_y <= 18'sd43254;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dgr_pkg::CFG_POS_X:   r_pos_x   <= i_cfg_data;
                dgr_pkg::CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                dgr_pkg::CFG_DIR_X:   r_dir_x   <= i_cfg_data[17:0];
                dgr_pkg::CFG_DIR_Y:   r_dir_y   <= i_cfg_data[17:0];
                dgr_pkg::CFG_PLANE_X: r_plane_x <= i_cfg_data[17:0];
                dgr_pkg::CFG_PLANE_Y: r_plane_y <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // slice height and color for the result
    assign lh   = (r_dist == '0) ? 40'(4 * dgr_pkg::SCREEN_H) : r_lh;
    assign half = lh >> 1;
    assign big  = (half >= 40'(dgr_pkg::SCREEN_H / 2));
    assign cval = r_side ? {1'b0, r_cell[7:1]} : r_cell;

    always_ff @(posedge i_clk) begin
        case (r_state)
            dgr_pkg::S_IDLE: begin
                if (cast_req) begin
                    r_col  <= i_column;
                    r_cam  <= $signed({1'b0, cam_prod[dgr_pkg::CAM_SHIFT+17:dgr_pkg::CAM_SHIFT]})
                            - $signed(19'(dgr_pkg::ONE));
                    r_mx   <= {2'b0, r_pos_x[20:F]};
                    r_my   <= {2'b0, r_pos_y[20:F]};
                    r_n    <= '0;
                    r_hit  <= 1'b0;
                    r_side <= 1'b0;
                    r_sdx  <= '0;
                    r_sdy  <= '0;
                end
            end
            dgr_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    case (r_op)
                        dgr_pkg::OP_DX:   r_dx   <= div_q;
                        dgr_pkg::OP_SDX:  r_sdx  <= div_q;
                        dgr_pkg::OP_DY:   r_dy   <= div_q;
                        dgr_pkg::OP_SDY:  r_sdy  <= div_q;
                        dgr_pkg::OP_DIST: r_dist <= q_sat;
                        dgr_pkg::OP_LH:   r_lh   <= div_q;
                        default: ;
                    endcase
                end
            end
            dgr_pkg::S_MUL: r_prod <= 37'(r_plane_x) * 37'(r_cam);
            dgr_pkg::S_RAYX: begin
                r_rx   <= n_rx;
                r_prod <= 37'(r_plane_y) * 37'(r_cam);
            end
            dgr_pkg::S_RAYY: r_ry <= n_ry;
            dgr_pkg::S_STEP: begin
                r_mx   <= s_mx;
                r_my   <= s_my;
                r_sdx  <= s_sdx;
                r_sdy  <= s_sdy;
                r_side <= !take_x;
            end
            dgr_pkg::S_CHECK: begin
                if (map_rdata != 8'd0) begin
                    r_hit  <= 1'b1;
                    r_cell <= map_rdata;
                    // zero ray component on the hit side
                    if (r_side && yinf) r_dist <= dgr_pkg::DIST_MAX;
                end else begin
                    r_n <= r_n + 1'b1;
                end
            end
            dgr_pkg::S_FINISH: begin
                r_out_column <= r_col;
                if (r_hit) begin
                    r_draw_start    <= big ? 11'd0
                                     : 11'(40'(dgr_pkg::SCREEN_H / 2) - half);
                    r_draw_end      <= big ? 11'(dgr_pkg::SCREEN_H - 1)
                                     : 11'(half + 40'(dgr_pkg::SCREEN_H / 2));
                    r_color_code    <= (cval <= 8'd3) ? cval[2:0] : dgr_pkg::COLOR_BLACK;
                    r_hit_side      <= r_side;
                    r_wall_distance <= r_dist;
                    r_escaped       <= 1'b0;
                end else begin
                    r_draw_start    <= 11'd0;
                    r_draw_end      <= 11'd0;
                    r_color_code    <= dgr_pkg::COLOR_BLACK;
                    r_hit_side      <= 1'b0;
                    r_wall_distance <= dgr_pkg::DIST_MAX;
                    r_escaped       <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_valid         = r_valid;
    assign o_out_column    = r_out_column;
    assign o_draw_start    = r_draw_start;
    assign o_draw_end      = r_draw_end;
    assign o_color_code    = r_color_code;
    assign o_hit_side      = r_hit_side;
    assign o_wall_distance = r_wall_distance;
    assign o_escaped       = r_escaped;

    `DGR_ASSERT(a_valid_pulse, i_clk, i_rst_n, o_valid |=> !o_valid)
    `DGR_ASSERT(a_cast_busy, i_clk, i_rst_n, cast_req |=> busy)
    `DGR_ASSERT(a_check_after_step, i_clk, i_rst_n, (r_state == dgr_pkg::S_CHECK) |-> ($past(r_state) == dgr_pkg::S_STEP))
    `DGR_ASSERT(a_escape_fixed, i_clk, i_rst_n, (o_valid && o_escaped) |-> ((o_wall_distance == dgr_pkg::DIST_MAX) && (o_color_code == dgr_pkg::COLOR_BLACK)))
    `DGR_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n |=> (!o_valid && busy))

endmodule
